@@ src/plle_pkg.sv @@
// Shared package of the positional linked list engine.
// Holds field widths, request and status codes, and the command and status
// structs between the controller and the datapath. Depends on nothing.
package plle_pkg;

  localparam int DefCapacity  = 64;
  localparam int DefValueBits = 32;

  localparam int ModeW     = 2;
  localparam int PosW      = 7;
  localparam int ValInW    = 32;
  localparam int StatusW   = 2;
  localparam int LenW      = 7;
  localparam int InTdataW  = 40;
  localparam int OutTdataW = 48;
  localparam int OutPadW   = OutTdataW - (StatusW + ValInW + LenW + 2);

  typedef enum logic [ModeW-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_GET    = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_e;

  localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_RANGE = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    LRA_FIRST = 2'd0,
    LRA_CUR   = 2'd1,
    LRA_RDATA = 2'd2
  } link_ra_e;

  typedef enum logic [1:0] {
    VRA_FIRST = 2'd0,
    VRA_CUR   = 2'd1,
    VRA_LINK  = 2'd2
  } val_ra_e;

  typedef enum logic {
    LWA_SLOT = 1'b0,
    LWA_CUR  = 1'b1
  } link_wa_e;

  typedef enum logic [1:0] {
    LWD_FIRST = 2'd0,
    LWD_LINK  = 2'd1,
    LWD_SLOT  = 2'd2
  } link_wd_e;

  typedef enum logic [1:0] {
    SS_HOLD  = 2'd0,
    SS_POP   = 2'd1,
    SS_FIRST = 2'd2,
    SS_LINK  = 2'd3
  } slot_sel_e;

  typedef enum logic [1:0] {
    FS_HOLD = 2'd0,
    FS_SLOT = 2'd1,
    FS_LINK = 2'd2
  } first_sel_e;

  typedef struct packed {
    logic       load;
    logic       status_cap;
    logic       walk_init;
    logic       walk_step;
    link_ra_e   link_ra;
    val_ra_e    val_ra;
    logic       link_we;
    link_wa_e   link_wa;
    link_wd_e   link_wd;
    logic       val_we;
    slot_sel_e  slot_sel;
    first_sel_e first_sel;
    logic       push;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       vout_cap;
    logic       last_cap;
    logic       res_load;
  } plle_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  req_ok;
    logic  head_op;
    logic  no_hops;
    logic  walk_last;
    logic  out_free;
  } plle_stat_t;

endpackage

@@ src/plle_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the node value, node link and free slot stores. No dependencies.
module plle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/plle_dpath.sv @@
// Datapath of the positional linked list engine: request and result registers,
// list bookkeeping, link walk and the three stores. Depends on plle_pkg and plle_ram.
module plle_dpath import plle_pkg::*; #(
  parameter int CAPACITY   = DefCapacity,
  parameter int VALUE_BITS = DefValueBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  plle_cmd_t            cmd_i,
  output plle_stat_t           stat_o,
  input  logic [InTdataW-1:0]  in_tdata_i,
  input  logic [ModeW-1:0]     in_tuser_i,
  input  logic                 out_tready_i,
  output logic                 out_tvalid_o,
  output logic [OutTdataW-1:0] out_tdata_o
);

  localparam int SW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > PosW) ? CW : PosW) + 1;

  mode_e                 mode_q;
  logic [PosW-1:0]       pos_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [StatusW-1:0]    status_q;
  logic [VALUE_BITS-1:0] vout_q;
  logic                  last_q;
  logic [SW-1:0]         slot_q;
  logic [SW-1:0]         cur_q;
  logic [CW-1:0]         hops_q;
  logic [SW-1:0]         first_q;
  logic [CW-1:0]         count_q;
  logic [CW-1:0]         sp_q;
  logic [CW-1:0]         fresh_q;
  logic                  out_valid_q;
  logic [StatusW-1:0]    out_status_q;
  logic [ValInW-1:0]     out_vout_q;
  logic [LenW-1:0]       out_len_q;
  logic                  out_empty_q;
  logic                  out_last_q;

  logic [VALUE_BITS+ValInW-1:0] val_in_ext;
  logic [VALUE_BITS+ValInW-1:0] vout_ext;
  logic [CW+LenW-1:0]           len_ext;
  logic [CMPW-1:0]              pos_x;
  logic [CMPW-1:0]              cnt_x;
  logic [CMPW-1:0]              bound;
  logic [CMPW-1:0]              hops_x;
  logic [CW-1:0]                hops_init;
  logic                         pos_bad;
  logic                         full;
  logic [StatusW-1:0]           status_code;
  logic [SW-1:0]                pop_slot;
  logic [CW-1:0]                sp_m1;

  logic [SW-1:0]         link_raddr;
  logic [SW-1:0]         link_waddr;
  logic [SW-1:0]         link_wdata;
  logic [SW-1:0]         link_rdata;
  logic [SW-1:0]         val_raddr;
  logic [VALUE_BITS-1:0] val_rdata;
  logic [SW-1:0]         stack_rdata;

  assign val_in_ext = {{VALUE_BITS{1'b0}}, in_tdata_i[PosW+ValInW-1:PosW]};
  assign vout_ext   = {{ValInW{1'b0}}, vout_q};
  assign len_ext    = {{LenW{1'b0}}, count_q};

  assign pos_x   = CMPW'(pos_q);
  assign cnt_x   = CMPW'(count_q);
  assign bound   = (mode_q == MODE_INSERT) ? cnt_x + CMPW'(1) : cnt_x;
  assign pos_bad = (mode_q != MODE_QUERY) && ((pos_q == '0) || (pos_x > bound));
  assign full    = (count_q >= CW'(CAPACITY));

  always_comb begin
    status_code = STATUS_OK;
    if (pos_bad) begin
      status_code = STATUS_RANGE;
    end else if ((mode_q == MODE_INSERT) && full) begin
      status_code = STATUS_FULL;
    end
  end

  assign hops_x    = pos_x - ((mode_q == MODE_GET) ? CMPW'(1) : CMPW'(2));
  assign hops_init = hops_x[CW-1:0];

  assign stat_o.mode      = mode_q;
  assign stat_o.req_ok    = (status_code == STATUS_OK);
  assign stat_o.head_op   = (mode_q != MODE_GET) && (pos_q == PosW'(1));
  assign stat_o.no_hops   = (hops_init == '0);
  assign stat_o.walk_last = (hops_q == CW'(1));
  assign stat_o.out_free  = !out_valid_q || out_tready_i;

  assign sp_m1    = sp_q - CW'(1);
  assign pop_slot = (sp_q != '0) ? stack_rdata : fresh_q[SW-1:0];

  always_comb begin
    case (cmd_i.link_ra)
      LRA_FIRST: link_raddr = first_q;
      LRA_CUR:   link_raddr = cur_q;
      LRA_RDATA: link_raddr = link_rdata;
      default:   link_raddr = first_q;
    endcase
    case (cmd_i.val_ra)
      VRA_FIRST: val_raddr = first_q;
      VRA_CUR:   val_raddr = cur_q;
      VRA_LINK:  val_raddr = link_rdata;
      default:   val_raddr = first_q;
    endcase
    case (cmd_i.link_wa)
      LWA_SLOT: link_waddr = slot_q;
      LWA_CUR:  link_waddr = cur_q;
      default:  link_waddr = slot_q;
    endcase
    case (cmd_i.link_wd)
      LWD_FIRST: link_wdata = first_q;
      LWD_LINK:  link_wdata = link_rdata;
      LWD_SLOT:  link_wdata = slot_q;
      default:   link_wdata = first_q;
    endcase
  end

  plle_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  plle_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.val_we),
    .waddr_i (slot_q),
    .wdata_i (val_q),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  plle_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (sp_q[SW-1:0]),
    .wdata_i (slot_q),
    .raddr_i (sp_m1[SW-1:0]),
    .rdata_o (stack_rdata)
  );

  // Request, walk and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_e'(in_tuser_i);
      pos_q  <= in_tdata_i[PosW-1:0];
      val_q  <= val_in_ext[VALUE_BITS-1:0];
      vout_q <= '0;
      last_q <= 1'b0;
    end
    if (cmd_i.status_cap) begin
      status_q <= status_code;
    end
    case (cmd_i.slot_sel)
      SS_POP:   slot_q <= pop_slot;
      SS_FIRST: slot_q <= first_q;
      SS_LINK:  slot_q <= link_rdata;
      default:  slot_q <= slot_q;
    endcase
    if (cmd_i.walk_init) begin
      cur_q  <= first_q;
      hops_q <= hops_init;
    end else if (cmd_i.walk_step) begin
      cur_q  <= link_rdata;
      hops_q <= hops_q - CW'(1);
    end
    if (cmd_i.vout_cap) begin
      vout_q <= val_rdata;
    end
    if (cmd_i.last_cap) begin
      last_q <= (pos_x == cnt_x);
    end
    if (cmd_i.res_load) begin
      out_status_q <= status_q;
      out_vout_q   <= vout_ext[ValInW-1:0];
      out_len_q    <= len_ext[LenW-1:0];
      out_empty_q  <= (count_q == '0);
      out_last_q   <= last_q;
    end
  end

  // List bookkeeping and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= '0;
      count_q     <= '0;
      sp_q        <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i.first_sel)
        FS_SLOT: first_q <= slot_q;
        FS_LINK: first_q <= link_rdata;
        default: first_q <= first_q;
      endcase
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.slot_sel == SS_POP) begin
        if (sp_q != '0) begin
          sp_q <= sp_m1;
        end else begin
          fresh_q <= fresh_q + CW'(1);
        end
      end else if (cmd_i.push) begin
        sp_q <= sp_q + CW'(1);
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = {{OutPadW{1'b0}}, out_last_q, out_empty_q, out_len_q,
                         out_vout_q, out_status_q};

endmodule

@@ src/plle_ctrl.sv @@
// Controller state machine of the positional linked list engine.
// Sequences check, walk, store updates and result hand-off. Depends on plle_pkg.
module plle_ctrl import plle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_tvalid_i,
  output logic       in_tready_o,
  input  plle_stat_t stat_i,
  output plle_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE        = 4'd0;
  localparam logic [3:0] S_DECODE      = 4'd1;
  localparam logic [3:0] S_WALK        = 4'd2;
  localparam logic [3:0] S_INS_HEAD    = 4'd3;
  localparam logic [3:0] S_INS_RD      = 4'd4;
  localparam logic [3:0] S_INS_W1      = 4'd5;
  localparam logic [3:0] S_INS_W2      = 4'd6;
  localparam logic [3:0] S_DEL_HEAD_RD = 4'd7;
  localparam logic [3:0] S_DEL_HEAD_W  = 4'd8;
  localparam logic [3:0] S_DEL_RD1     = 4'd9;
  localparam logic [3:0] S_DEL_RD2     = 4'd10;
  localparam logic [3:0] S_DEL_W       = 4'd11;
  localparam logic [3:0] S_GET_RD      = 4'd12;
  localparam logic [3:0] S_GET_CAP     = 4'd13;
  localparam logic [3:0] S_RESULT      = 4'd14;

  logic [3:0] state_q;
  logic [3:0] state_d;
  logic [3:0] after_walk;

  always_comb begin
    case (stat_i.mode)
      MODE_INSERT: after_walk = S_INS_RD;
      MODE_DELETE: after_walk = S_DEL_RD1;
      default:     after_walk = S_GET_RD;
    endcase
  end

  assign in_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.status_cap = 1'b1;
        cmd_o.walk_init  = 1'b1;
        cmd_o.link_ra    = LRA_FIRST;
        if (!stat_i.req_ok || (stat_i.mode == MODE_QUERY)) begin
          state_d = S_RESULT;
        end else begin
          if (stat_i.mode == MODE_INSERT) begin
            cmd_o.slot_sel = SS_POP;
          end
          if (stat_i.head_op) begin
            state_d = (stat_i.mode == MODE_INSERT) ? S_INS_HEAD : S_DEL_HEAD_RD;
          end else if (stat_i.no_hops) begin
            state_d = after_walk;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        cmd_o.link_ra   = LRA_RDATA;
        if (stat_i.walk_last) begin
          state_d = after_walk;
        end
      end
      S_INS_HEAD: begin
        cmd_o.val_we    = 1'b1;
        cmd_o.link_we   = 1'b1;
        cmd_o.link_wa   = LWA_SLOT;
        cmd_o.link_wd   = LWD_FIRST;
        cmd_o.first_sel = FS_SLOT;
        cmd_o.cnt_inc   = 1'b1;
        state_d         = S_RESULT;
      end
      S_INS_RD: begin
        cmd_o.link_ra = LRA_CUR;
        state_d       = S_INS_W1;
      end
      S_INS_W1: begin
        cmd_o.val_we  = 1'b1;
        cmd_o.link_we = 1'b1;
        cmd_o.link_wa = LWA_SLOT;
        cmd_o.link_wd = LWD_LINK;
        state_d       = S_INS_W2;
      end
      S_INS_W2: begin
        cmd_o.link_we = 1'b1;
        cmd_o.link_wa = LWA_CUR;
        cmd_o.link_wd = LWD_SLOT;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_RESULT;
      end
      S_DEL_HEAD_RD: begin
        cmd_o.slot_sel = SS_FIRST;
        cmd_o.link_ra  = LRA_FIRST;
        cmd_o.val_ra   = VRA_FIRST;
        state_d        = S_DEL_HEAD_W;
      end
      S_DEL_HEAD_W: begin
        cmd_o.first_sel = FS_LINK;
        cmd_o.vout_cap  = 1'b1;
        cmd_o.push      = 1'b1;
        cmd_o.cnt_dec   = 1'b1;
        state_d         = S_RESULT;
      end
      S_DEL_RD1: begin
        cmd_o.link_ra = LRA_CUR;
        state_d       = S_DEL_RD2;
      end
      S_DEL_RD2: begin
        cmd_o.slot_sel = SS_LINK;
        cmd_o.link_ra  = LRA_RDATA;
        cmd_o.val_ra   = VRA_LINK;
        state_d        = S_DEL_W;
      end
      S_DEL_W: begin
        cmd_o.link_we  = 1'b1;
        cmd_o.link_wa  = LWA_CUR;
        cmd_o.link_wd  = LWD_LINK;
        cmd_o.vout_cap = 1'b1;
        cmd_o.push     = 1'b1;
        cmd_o.cnt_dec  = 1'b1;
        state_d        = S_RESULT;
      end
      S_GET_RD: begin
        cmd_o.val_ra = VRA_CUR;
        state_d      = S_GET_CAP;
      end
      S_GET_CAP: begin
        cmd_o.vout_cap = 1'b1;
        cmd_o.last_cap = 1'b1;
        state_d        = S_RESULT;
      end
      S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/positional_linked_list_engine_unit.sv @@
// Positional linked list engine: a bounded ordered list of CAPACITY unsigned values
// that takes insert, delete, get and query requests, one at a time, and returns
// one result transaction per request. A request reaches its position by following
// links from the first node, one hop per cycle through the link store's read port,
// so the time from acceptance to result grows with the position; a query or a
// rejected request goes from the check straight to the result. Free slots are
// handed out from a fill count and a stack of released slots, so no clearing pass
// follows reset. A finished result waits in an output register and the next request
// is accepted meanwhile. Depends on plle_pkg, plle_ctrl, plle_dpath and plle_ram.
module positional_linked_list_engine_unit import plle_pkg::*; #(
  parameter int CAPACITY   = DefCapacity,
  parameter int VALUE_BITS = DefValueBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // position [6:0], value_in [38:7], zero [39]
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // mode [1:0]
  input  logic [ModeW-1:0]     s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // status [1:0], value_out [33:2], list_length [40:34], is_empty [41],
  // is_last [42], zero [47:43]
  output logic [OutTdataW-1:0] m_axis_tdata
);

  plle_cmd_t  cmd;
  plle_stat_t stat;

  plle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_tready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  plle_dpath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .out_tready_i (m_axis_tready),
    .out_tvalid_o (m_axis_tvalid),
    .out_tdata_o  (m_axis_tdata)
  );

endmodule
